@@ design/id3_pkg.sv @@
`default_nettype none
package id3_pkg;

    localparam int WinLen = 16;

    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_PIC   = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_NOTAG = 2'd3;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_FHDR    = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_IDLE    = 2'd3;

    localparam logic [3:0] FIELD_PIC  = 4'd8;
    localparam logic [3:0] FIELD_NONE = 4'd15;

    // search limits for signature starts
    localparam logic [27:0] JPEG_K_MIN = 28'd2;
    localparam logic [27:0] JPEG_K_MAX = 28'd21;
    localparam logic [27:0] PNG_K_MIN  = 28'd15;
    localparam logic [27:0] PNG_K_MAX  = 28'd34;
    localparam logic [27:0] PNG_K_REP  = 28'd21;

    localparam logic [7:0] PNG_SIG [WinLen] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
        8'h00, 8'h00, 8'h00, 8'h0D, 8'h49, 8'h48, 8'h44, 8'h52};

    localparam logic [31:0] IDS_V22 [9] = '{
        32'h00545031, 32'h00545432, 32'h0054414C, 32'h0054524B, 32'h00545945,
        32'h00544C45, 32'h00434F4D, 32'h0054434F, 32'h00504943};
    localparam logic [31:0] IDS_V23 [9] = '{
        32'h54504531, 32'h54495432, 32'h54414C42, 32'h5452434B, 32'h54594552,
        32'h544C454E, 32'h434F4D4D, 32'h54434F4E, 32'h41504943};

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  field_code;
        logic [7:0]  text_byte;
        logic [2:0]  version;
        logic        picture_type;
        logic [28:0] picture_offset;
        logic [27:0] picture_length;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [1:0] cnt;
        t_res       res_a;
        t_res       res_b;
    } t_push;

    function automatic logic [3:0] classify(input logic [31:0] ident, input logic is_v22);
        logic [3:0] code;
        code = FIELD_NONE;
        for (int i = 8; i >= 0; i--) begin
            if ((is_v22 ? IDS_V22[i] : IDS_V23[i]) == ident) begin
                code = 4'(i);
            end
        end
        return code;
    endfunction

    function automatic t_res mk_res(input logic [1:0] kind, input logic [2:0] code,
                                    input logic [7:0] tb, input logic [2:0] ver,
                                    input logic ptype, input logic [28:0] off,
                                    input logic [27:0] len);
        t_res r;
        r.kind           = kind;
        r.field_code     = code;
        r.text_byte      = tb;
        r.version        = (kind == KIND_NOTAG) ? 3'd0 : ver;
        r.picture_type   = ptype;
        r.picture_offset = off;
        r.picture_length = len;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/id3v2_frame_parser_top.sv @@
// A byte is registered on acceptance, and its results are written into the
// result queue before they are presented on the master side.
// Throughput: one byte per cycle while the result queue has space; a byte yields
// up to two results, drained one per cycle while the master is ready, through a four-entry result queue.
// Reset: synchronous, active low; parser returns to awaiting the tag header,
// queue is emptied.
`default_nettype none
module id3v2_frame_parser_top
    import id3_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tlast,   // end_of_file
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] field_code, [10:3] text_byte, [13:11] version, [14] picture_type,
    // [43:15] picture_offset, [71:44] picture_length
    output logic [71:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // kind
    output logic             m_axis_tlast    // last
);

    t_push w_push;
    logic  w_space;
    t_res  w_res;

    id3_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_eof   (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_space (w_space),
        .o_push  (w_push)
    );

    id3_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_space (w_space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    assign m_axis_tdata = {w_res.picture_length, w_res.picture_offset, w_res.picture_type,
                           w_res.version, w_res.text_byte, w_res.field_code};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;

    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt != 2'd0) |-> w_space)
        else $error("result request written without queue space");

    a_notag_ver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_NOTAG) |-> (m_axis_tdata[13:11] == 3'd0))
        else $error("no-tag result carries a version");

    a_text_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_TEXT) |-> (m_axis_tdata[10:3] == 8'd0))
        else $error("text byte set on non-text result");

endmodule
`default_nettype wire

@@ design/id3_parse.sv @@
`default_nettype none
module id3_parse
    import id3_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_eof,
    output logic            o_ready,
    input  wire logic       i_space,
    output t_push           o_push
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eof;

    logic [1:0]  r_phase, n_phase;
    logic [28:0] r_pos, n_pos;
    logic [27:0] r_trem, n_trem;
    logic [2:0]  r_mv, n_mv;
    logic [3:0]  r_hc, n_hc;
    logic [31:0] r_ident, n_ident;
    logic [31:0] r_fsize, n_fsize;
    logic [27:0] r_fleft, n_fleft;
    logic [3:0]  r_field, n_field;
    logic        r_mvalid, n_mvalid;
    logic [28:0] r_moff, n_moff;
    logic [7:0]  r_win [WinLen];
    logic [7:0]  n_win [WinLen];

    logic step;
    assign step    = r_in_valid && i_space;
    assign o_ready = !r_in_valid || i_space;

    always_comb begin
        logic [7:0]  b;
        logic        bad, stop, is2, png_ok, ending;
        logic [3:0]  idlen, hlen, hc1;
        logic [27:0] trem_d, idx, fl, k, skip;
        logic        v0, v1, v2;
        t_res        c0, c1, c2;
        b        = r_in_byte;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_trem   = r_trem;
        n_mv     = r_mv;
        n_hc     = r_hc;
        n_ident  = r_ident;
        n_fsize  = r_fsize;
        n_fleft  = r_fleft;
        n_field  = r_field;
        n_mvalid = r_mvalid;
        n_moff   = r_moff;
        n_win    = r_win;
        bad = 1'b0; stop = 1'b0; png_ok = 1'b0; ending = 1'b0;
        is2   = (r_mv == 3'd2);
        idlen = is2 ? 4'd3 : 4'd4;
        hlen  = is2 ? 4'd6 : 4'd10;
        hc1   = r_hc + 4'd1;
        trem_d = r_trem - 28'd1;
        idx   = r_fsize[27:0] - r_fleft;
        fl    = r_fleft - 28'd1;
        skip  = is2 ? 28'd6 : 28'd13;
        k     = idx - skip;
        v0 = 1'b0; v1 = 1'b0; v2 = 1'b0;
        c0 = '0; c1 = '0; c2 = '0;
        if (step) begin
            n_pos = r_pos + 29'd1;
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_hc == 4'd0) begin
                        bad = (b != 8'h49);
                    end else if (r_hc == 4'd1) begin
                        bad = (b != 8'h44);
                    end else if (r_hc == 4'd2) begin
                        bad = (b != 8'h33);
                    end else if (r_hc == 4'd3) begin
                        if (b < 8'd2 || b > 8'd4) begin
                            bad = 1'b1;
                        end else begin
                            n_mv = b[2:0];
                        end
                    end else if (r_hc >= 4'd6) begin
                        n_trem = {r_trem[20:0], b[6:0]};
                    end
                    if (bad) begin
                        n_mv = 3'd0;
                        v1 = 1'b1;
                        c1 = mk_res(KIND_NOTAG, 3'd0, 8'd0, 3'd0, 1'b0, '0, '0);
                        n_phase = PH_IDLE;
                    end else if (r_hc == 4'd9) begin
                        n_hc = 4'd0;
                        n_ident = '0;
                        n_fsize = '0;
                        if (n_trem == 28'd0) begin
                            v1 = 1'b1;
                            c1 = mk_res(KIND_DONE, 3'd0, 8'd0, r_mv, 1'b0, '0, '0);
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_FHDR;
                        end
                    end else begin
                        n_hc = hc1;
                    end
                end
                PH_FHDR: begin
                    n_trem = trem_d;
                    if (r_hc < idlen) begin
                        n_ident = {r_ident[23:0], b};
                        // zero in the first ID byte marks padding
                        if (r_hc == 4'd0 && b == 8'd0) begin
                            stop = 1'b1;
                        end
                    end else if (r_hc < {idlen[2:0], 1'b0}) begin
                        if (r_mv == 3'd4) begin
                            n_fsize = {r_fsize[24:0], b[6:0]};
                        end else begin
                            n_fsize = {r_fsize[23:0], b};
                        end
                    end
                    if (!stop) begin
                        if (hc1 >= hlen) begin
                            if (n_fsize == 32'd0 || n_fsize > {4'd0, trem_d}) begin
                                stop = 1'b1;
                            end else begin
                                n_fleft  = n_fsize[27:0];
                                n_field  = classify(n_ident, is2);
                                n_mvalid = 1'b0;
                                n_phase  = PH_PAYLOAD;
                                hc1 = 4'd0;
                            end
                        end else if (trem_d == 28'd0) begin
                            stop = 1'b1;
                        end
                    end
                    n_hc = hc1;
                    if (stop) begin
                        v1 = 1'b1;
                        c1 = mk_res(KIND_DONE, 3'd0, 8'd0, r_mv, 1'b0, '0, '0);
                        n_phase = PH_IDLE;
                    end
                end
                PH_PAYLOAD: begin
                    n_trem  = trem_d;
                    n_fleft = fl;
                    if (r_field < FIELD_PIC) begin
                        // drop the encoding byte and anything outside the printable range
                        if (idx != 28'd0 && b >= 8'h20 && b <= 8'hFD) begin
                            v0 = 1'b1;
                            c0 = mk_res(KIND_TEXT, r_field[2:0], b, r_mv, 1'b0, '0, '0);
                        end
                    end else if (r_field == FIELD_PIC) begin
                        if (idx >= skip) begin
                            ending = (fl == 28'd0) || r_in_eof;
                            for (int i = 0; i < WinLen - 1; i++) begin
                                n_win[i] = r_win[i + 1];
                            end
                            n_win[WinLen - 1] = b;
                            png_ok = 1'b1;
                            for (int i = 0; i < WinLen; i++) begin
                                if (n_win[i] != PNG_SIG[i]) begin
                                    png_ok = 1'b0;
                                end
                            end
                            if (k >= JPEG_K_MIN && k <= JPEG_K_MAX &&
                                n_win[WinLen - 3] == 8'hFF && n_win[WinLen - 2] == 8'hD8 &&
                                n_win[WinLen - 1] == 8'hFF) begin
                                n_field = FIELD_NONE;
                                v0 = 1'b1;
                                c0 = mk_res(KIND_PIC, 3'd0, 8'd0, r_mv, 1'b0,
                                            r_pos - 29'd2, fl + 28'd3);
                            end else begin
                                if (k >= PNG_K_MIN && k <= PNG_K_MAX && !r_mvalid && png_ok) begin
                                    n_mvalid = 1'b1;
                                    n_moff   = r_pos - 29'd15;
                                end
                                if ((k >= PNG_K_REP || ending) && n_mvalid) begin
                                    n_field = FIELD_NONE;
                                    v0 = 1'b1;
                                    c0 = mk_res(KIND_PIC, 3'd0, 8'd0, r_mv, 1'b1, n_moff,
                                                fl + 28'(r_pos - n_moff) + 28'd1);
                                end else if (ending || k >= PNG_K_MAX) begin
                                    n_field = FIELD_NONE;
                                end
                            end
                        end else if (fl == 28'd0) begin
                            n_field = FIELD_NONE;
                        end
                    end
                    if (fl == 28'd0) begin
                        n_phase = PH_FHDR;
                        n_hc    = 4'd0;
                        n_ident = '0;
                        n_fsize = '0;
                        n_field = FIELD_NONE;
                        if (trem_d == 28'd0) begin
                            v1 = 1'b1;
                            c1 = mk_res(KIND_DONE, 3'd0, 8'd0, r_mv, 1'b0, '0, '0);
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (r_in_eof) begin
                if (n_phase == PH_HEADER) begin
                    v2 = 1'b1;
                    c2 = mk_res(KIND_NOTAG, 3'd0, 8'd0, 3'd0, 1'b0, '0, '0);
                end else if (n_phase != PH_IDLE) begin
                    v2 = 1'b1;
                    c2 = mk_res(KIND_DONE, 3'd0, 8'd0, r_mv, 1'b0, '0, '0);
                end
                n_phase  = PH_HEADER;
                n_pos    = '0;
                n_trem   = '0;
                n_mv     = '0;
                n_hc     = '0;
                n_ident  = '0;
                n_fsize  = '0;
                n_fleft  = '0;
                n_field  = FIELD_NONE;
                n_mvalid = 1'b0;
                n_moff   = '0;
            end
        end
        // compact up to three candidates into two slots, in order
        o_push.cnt   = 2'(v0) + 2'(v1) + 2'(v2);
        o_push.res_a = v0 ? c0 : (v1 ? c1 : c2);
        o_push.res_b = (v0 && v1) ? c1 : c2;
        if (o_push.cnt == 2'd1) begin
            o_push.res_a.last = 1'b1;
        end
        if (o_push.cnt == 2'd2) begin
            o_push.res_b.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_HEADER;
            r_pos      <= '0;
            r_trem     <= '0;
            r_mv       <= '0;
            r_hc       <= '0;
            r_ident    <= '0;
            r_fsize    <= '0;
            r_fleft    <= '0;
            r_field    <= FIELD_NONE;
            r_mvalid   <= 1'b0;
            r_moff     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_trem   <= n_trem;
            r_mv     <= n_mv;
            r_hc     <= n_hc;
            r_ident  <= n_ident;
            r_fsize  <= n_fsize;
            r_fleft  <= n_fleft;
            r_field  <= n_field;
            r_mvalid <= n_mvalid;
            r_moff   <= n_moff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_eof  <= i_eof;
        end
        r_win <= n_win;
    end

endmodule
`default_nettype wire

@@ design/id3_outq.sv @@
`default_nettype none
module id3_outq
    import id3_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_push i_push,
    output logic      o_space,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_res
);

    t_res       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_space = (r_cnt <= 3'd2);
    assign o_res   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.res_a;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_push.res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_push.cnt;
            r_rp  <= r_rp + 2'(pop);
            r_cnt <= r_cnt + 3'(i_push.cnt) - 3'(pop);
        end
    end

endmodule
`default_nettype wire

@@ sim/id3v2_frame_parser_top_test.sv @@
`timescale 1ns / 1ps
`default_nettype none
module id3v2_frame_parser_top_test;
    import id3_pkg::*;

    localparam int PNG_LEN = 16;
    localparam int WINDOW  = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    id3v2_frame_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // parser mirror
    logic [1:0]  tag_phase;
    logic [28:0] byte_pos;
    logic [29:0] bytes_in_tag;
    logic [2:0]  tag_version;
    logic [3:0]  hdr_count;
    logic [31:0] frm_ident;
    logic [31:0] frm_size;
    logic [27:0] frm_left;
    logic [3:0]  text_field;
    logic [7:0]  sig_window [PNG_LEN];
    logic        png_seen;
    logic [28:0] png_offset;

    t_res results_due [$];
    int   error_count;
    int   send_idle_pct;
    int   recv_stall_pct;

    function automatic t_res make_result(logic [1:0] kind, logic [2:0] code, logic [7:0] tb,
                                         logic ptype, logic [28:0] off, logic [27:0] len);
        t_res r;
        r.kind           = kind;
        r.field_code     = code;
        r.text_byte      = tb;
        r.version        = (kind == KIND_NOTAG) ? 3'd0 : tag_version;
        r.picture_type   = ptype;
        r.picture_offset = off;
        r.picture_length = len;
        r.last           = 1'b0;
        return r;
    endfunction

    task automatic clear_parser();
        tag_phase    = PH_HEADER;
        byte_pos     = '0;
        bytes_in_tag = '0;
        tag_version  = '0;
        hdr_count    = '0;
        frm_ident    = '0;
        frm_size     = '0;
        frm_left     = '0;
        text_field   = FIELD_NONE;
        png_seen     = 1'b0;
        png_offset   = '0;
        for (int i = 0; i < PNG_LEN; i++) sig_window[i] = 8'h00;
    endtask

    function automatic logic [3:0] frame_field(logic [31:0] id);
        logic [3:0] code;
        code = FIELD_NONE;
        for (int i = 8; i >= 0; i--) begin
            if (((tag_version == 3'd2) ? IDS_V22[i] : IDS_V23[i]) == id) code = 4'(i);
        end
        return code;
    endfunction

    // advance the picture search by one payload byte
    task automatic scan_picture(logic [7:0] b, logic [27:0] k, logic [28:0] pos, logic ending,
                                inout t_res out [$]);
        logic        png_hit;
        logic [28:0] gap;
        for (int i = 0; i < PNG_LEN - 1; i++) sig_window[i] = sig_window[i + 1];
        sig_window[PNG_LEN - 1] = b;
        if (k >= 2 && k - 2 < WINDOW && sig_window[PNG_LEN - 3] == 8'hFF
            && sig_window[PNG_LEN - 2] == 8'hD8 && sig_window[PNG_LEN - 1] == 8'hFF) begin
            text_field = FIELD_NONE;
            out.push_back(make_result(KIND_PIC, 3'd0, 8'd0, 1'b0, pos - 29'd2,
                                      frm_left + 28'd3));
            return;
        end
        png_hit = 1'b1;
        for (int i = 0; i < PNG_LEN; i++) if (sig_window[i] != PNG_SIG[i]) png_hit = 1'b0;
        if (k >= PNG_LEN - 1 && k - (PNG_LEN - 1) < WINDOW && !png_seen && png_hit) begin
            png_seen   = 1'b1;
            png_offset = pos - 29'(PNG_LEN - 1);
        end
        if ((k >= WINDOW + 1 || ending) && png_seen) begin
            text_field = FIELD_NONE;
            gap = pos - png_offset;
            out.push_back(make_result(KIND_PIC, 3'd0, 8'd0, 1'b1, png_offset,
                                      frm_left + 28'(gap) + 28'd1));
            return;
        end
        if (ending || k >= WINDOW + PNG_LEN - 2) text_field = FIELD_NONE;
    endtask

    task automatic parse_byte(logic [7:0] b, logic eof);
        t_res        out [$];
        logic [28:0] pos;
        logic [3:0]  hc;
        logic        bad;
        logic        stop;
        logic [3:0]  id_len;
        logic [3:0]  hdr_len;
        logic [31:0] idx;
        logic [31:0] skip;
        pos = byte_pos;
        if (tag_phase == PH_HEADER) begin
            hc  = hdr_count;
            bad = 1'b0;
            if (hc < 3) begin
                bad = (b != ((hc == 0) ? 8'h49 : (hc == 1) ? 8'h44 : 8'h33));
            end else if (hc == 3) begin
                if (b < 2 || b > 4) bad = 1'b1;
                else tag_version = b[2:0];
            end else if (hc >= 6) begin
                bytes_in_tag = {bytes_in_tag[22:0], b[6:0]} & 30'h0FFFFFFF;
            end
            if (bad) begin
                tag_version = '0;
                out.push_back(make_result(KIND_NOTAG, 0, 0, 0, 0, 0));
                tag_phase = PH_IDLE;
            end else if (hc + 1 >= 10) begin
                hdr_count = '0;
                frm_ident = '0;
                frm_size  = '0;
                if (bytes_in_tag == 0) begin
                    out.push_back(make_result(KIND_DONE, 0, 0, 0, 0, 0));
                    tag_phase = PH_IDLE;
                end else begin
                    tag_phase = PH_FHDR;
                end
            end else begin
                hdr_count = hc + 1;
            end
        end else if (tag_phase == PH_FHDR) begin
            hc      = hdr_count;
            id_len  = (tag_version == 2) ? 4'd3 : 4'd4;
            hdr_len = (tag_version == 2) ? 4'd6 : 4'd10;
            stop    = 1'b0;
            bytes_in_tag = bytes_in_tag - 1;
            if (hc < id_len) begin
                frm_ident = {frm_ident[23:0], b};
                if (hc == 0 && b == 0) stop = 1'b1;
            end else if (hc < 2 * id_len) begin
                if (tag_version == 4) frm_size = {frm_size[24:0], b[6:0]};
                else frm_size = {frm_size[23:0], b};
            end
            hc++;
            if (!stop) begin
                if (hc >= hdr_len) begin
                    if (frm_size == 0 || frm_size > 32'(bytes_in_tag)) begin
                        stop = 1'b1;
                    end else begin
                        frm_left   = frm_size[27:0];
                        text_field = frame_field(frm_ident);
                        png_seen   = 1'b0;
                        tag_phase  = PH_PAYLOAD;
                        hc = 0;
                    end
                end else if (bytes_in_tag == 0) begin
                    stop = 1'b1;
                end
            end
            hdr_count = hc;
            if (stop) begin
                out.push_back(make_result(KIND_DONE, 0, 0, 0, 0, 0));
                tag_phase = PH_IDLE;
            end
        end else if (tag_phase == PH_PAYLOAD) begin
            idx = frm_size - 32'(frm_left);
            bytes_in_tag = bytes_in_tag - 1;
            frm_left = frm_left - 1;
            if (text_field < FIELD_PIC) begin
                if (idx > 0 && b >= 8'h20 && b <= 8'hFD)
                    out.push_back(make_result(KIND_TEXT, text_field[2:0], b, 0, 0, 0));
            end else if (text_field == FIELD_PIC) begin
                skip = (tag_version == 2) ? 6 : 13;
                if (idx >= skip) scan_picture(b, 28'(idx - skip), pos, frm_left == 0 || eof, out);
                else if (frm_left == 0) text_field = FIELD_NONE;
            end
            if (frm_left == 0) begin
                tag_phase  = PH_FHDR;
                hdr_count  = '0;
                frm_ident  = '0;
                frm_size   = '0;
                text_field = FIELD_NONE;
                if (bytes_in_tag == 0) begin
                    out.push_back(make_result(KIND_DONE, 0, 0, 0, 0, 0));
                    tag_phase = PH_IDLE;
                end
            end
        end
        byte_pos = pos + 1;
        if (eof) begin
            if (tag_phase == PH_HEADER) begin
                tag_version = '0;
                out.push_back(make_result(KIND_NOTAG, 0, 0, 0, 0, 0));
            end else if (tag_phase != PH_IDLE) begin
                out.push_back(make_result(KIND_DONE, 0, 0, 0, 0, 0));
            end
            clear_parser();
        end
        if (out.size() > 0) out[out.size() - 1].last = 1'b1;
        foreach (out[i]) results_due.push_back(out[i]);
    endtask

    // send one byte; the prediction is made as the byte is accepted
    task automatic send_byte(logic [7:0] b, logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        parse_byte(b, eof);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                $error("unexpected result kind=%0d", m_axis_tuser);
                error_count++;
            end else begin
                want = results_due.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("kind exp %0d got %0d", want.kind, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[2:0] !== want.field_code) begin
                    $error("field_code exp %0d got %0d", want.field_code, m_axis_tdata[2:0]);
                    error_count++;
                end
                if (m_axis_tdata[10:3] !== want.text_byte) begin
                    $error("text_byte exp %0h got %0h", want.text_byte, m_axis_tdata[10:3]);
                    error_count++;
                end
                if (m_axis_tdata[13:11] !== want.version) begin
                    $error("version exp %0d got %0d", want.version, m_axis_tdata[13:11]);
                    error_count++;
                end
                if (m_axis_tdata[14] !== want.picture_type) begin
                    $error("picture_type exp %0d got %0d", want.picture_type, m_axis_tdata[14]);
                    error_count++;
                end
                if (m_axis_tdata[43:15] !== want.picture_offset) begin
                    $error("picture_offset exp %0d got %0d", want.picture_offset,
                           m_axis_tdata[43:15]);
                    error_count++;
                end
                if (m_axis_tdata[71:44] !== want.picture_length) begin
                    $error("picture_length exp %0d got %0d", want.picture_length,
                           m_axis_tdata[71:44]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last exp %0d got %0d", want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // file building helpers
    logic [7:0] file_buf [$];

    task automatic put_header(int ver, int size);
        file_buf.push_back(8'h49);
        file_buf.push_back(8'h44);
        file_buf.push_back(8'h33);
        file_buf.push_back(8'(ver));
        file_buf.push_back(8'($urandom));
        file_buf.push_back(8'($urandom));
        file_buf.push_back({1'b0, 7'(size >> 21)});
        file_buf.push_back({1'b0, 7'(size >> 14)});
        file_buf.push_back({1'b0, 7'(size >> 7)});
        file_buf.push_back({1'b0, 7'(size)});
    endtask

    task automatic put_frame_hdr(int ver, logic [31:0] id, int len);
        if (ver == 2) begin
            for (int i = 2; i >= 0; i--) file_buf.push_back(id[8 * i +: 8]);
            for (int i = 2; i >= 0; i--) file_buf.push_back(8'(len >> (8 * i)));
        end else begin
            for (int i = 3; i >= 0; i--) file_buf.push_back(id[8 * i +: 8]);
            for (int i = 3; i >= 0; i--)
                file_buf.push_back((ver == 4) ? {1'b0, 7'(len >> (7 * i))}
                                              : 8'(len >> (8 * i)));
            file_buf.push_back(8'($urandom));
            file_buf.push_back(8'($urandom));
        end
    endtask

    function automatic int hdr_size(int ver);
        return (ver == 2) ? 6 : 10;
    endfunction

    // picture payload: skip bytes, then maybe a JPEG signature, a PNG signature or both at random starts
    task automatic put_picture(int ver, int len);
        int skip;
        int start;
        int pick;
        logic [7:0] body [$];
        skip  = (ver == 2) ? 6 : 13;
        pick  = $urandom_range(3);
        start = skip + $urandom_range(WINDOW + 2);
        for (int i = 0; i < len; i++) body.push_back(8'($urandom));
        if (pick == 0) begin
            for (int i = 0; i < 3; i++)
                if (start + i < len) body[start + i] = (i == 1) ? 8'hD8 : 8'hFF;
        end else if (pick == 1) begin
            for (int i = 0; i < PNG_LEN; i++)
                if (start + i < len) body[start + i] = PNG_SIG[i];
        end else if (pick == 2) begin
            for (int i = 0; i < PNG_LEN; i++)
                if (start + i < len) body[start + i] = PNG_SIG[i];
            start = skip + $urandom_range(WINDOW + 2);
            for (int i = 0; i < 3; i++)
                if (start + i < len) body[start + i] = (i == 1) ? 8'hD8 : 8'hFF;
        end
        foreach (body[i]) file_buf.push_back(body[i]);
    endtask

    task automatic build_tag(int ver, int frames, logic broken);
        int sizes [$];
        int total;
        int pick;
        logic [31:0] ids [$];
        total = 0;
        for (int f = 0; f < frames; f++) begin
            pick = $urandom_range(9);
            ids.push_back((pick <= 8) ? ((ver == 2) ? IDS_V22[pick] : IDS_V23[pick])
                                      : ((ver == 2) ? 32'h00585858 : 32'h58585858));
            sizes.push_back((pick == 8) ? $urandom_range(5, 50) : $urandom_range(1, 12));
            total += hdr_size(ver) + sizes[f];
        end
        total += $urandom_range(3) * (($urandom_range(1)) ? 1 : 0);
        if (broken) total = $urandom_range(1, total + 2);
        put_header(ver, total);
        for (int f = 0; f < frames; f++) begin
            put_frame_hdr(ver, ids[f], sizes[f]);
            if (ids[f] == IDS_V22[8] || ids[f] == IDS_V23[8]) begin
                put_picture(ver, sizes[f]);
            end else begin
                for (int i = 0; i < sizes[f]; i++) file_buf.push_back(8'($urandom));
            end
        end
        repeat ($urandom_range(4)) file_buf.push_back(8'h00);
    endtask

    task automatic send_file();
        foreach (file_buf[i]) send_byte(file_buf[i], i == file_buf.size() - 1);
        file_buf.delete();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        // bad magic, two bad versions, empty tag, eof inside header
        file_buf = '{8'h58, 8'h00, 8'hFF};
        send_file();
        file_buf = '{8'h49, 8'h44, 8'h33, 8'h05, 8'h00};
        send_file();
        file_buf = '{8'h49, 8'h44, 8'h33, 8'h01};
        send_file();
        put_header(3, 0);
        file_buf.push_back(8'h41);
        send_file();
        file_buf = '{8'h49, 8'h44};
        send_file();
        // v2.2 text with all bytes extremes, then padding
        put_header(2, 30);
        put_frame_hdr(2, IDS_V22[0], 5);
        file_buf.push_back(8'h00);
        file_buf.push_back(8'h1F);
        file_buf.push_back(8'h20);
        file_buf.push_back(8'hFD);
        file_buf.push_back(8'hFE);
        file_buf.push_back(8'h00);
        send_file();
        // v2.4 picture with PNG, then zero length frame
        put_header(4, 90);
        put_frame_hdr(4, IDS_V23[8], 40);
        for (int i = 0; i < 13; i++) file_buf.push_back(8'h00);
        for (int i = 0; i < PNG_LEN; i++) file_buf.push_back(PNG_SIG[i]);
        for (int i = 0; i < 11; i++) file_buf.push_back(8'hFF);
        put_frame_hdr(4, IDS_V23[7], 0);
        send_file();
    endtask

    task automatic test_random(int files);
        int ver;
        for (int n = 0; n < files; n++) begin
            ver = $urandom_range(2, 4);
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 12)) file_buf.push_back(8'($urandom));
            end else begin
                build_tag(ver, $urandom_range(1, 4), $urandom_range(5) == 0);
            end
            send_file();
        end
    endtask

    task automatic wait_drained();
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b1;
        clear_parser();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(6);
        send_idle_pct = 48;
        test_random(6);
        send_idle_pct  = 0;
        recv_stall_pct = 48;
        test_random(6);
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        test_random(6);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(6);
        wait_drained();
        if (error_count == 0) begin
            $display("[id3v2_frame_parser_top] OK");
        end else begin
            $display("[id3v2_frame_parser_top] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[id3v2_frame_parser_top] ERROR");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
design/id3_pkg.sv
design/id3_parse.sv
design/id3_outq.sv
design/id3v2_frame_parser_top.sv
sim/id3v2_frame_parser_top_test.sv
